// File: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared widths, codes, control word layout and the microprogram of the
// sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    // field widths of the words on the two channels
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int DEPTH_DEF = 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_INS,
        C_FULL,
        C_EMPTY,
        C_IDX_ZERO,
        C_NOT_GT,
        C_EQ,
        C_NOT_LAST,
        C_LAST,
        C_NOT_DEL,
        C_OUT_BUSY
    } cond_t;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_USED,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    // memory read address select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX_M1,
        RD_IDX,
        RD_IDX_P1
    } rd_sel_t;

    // memory write data select, address is always the index register
    typedef enum logic [1:0] {
        WR_NONE,
        WR_DATA,
        WR_VAL
    } wr_sel_t;

    // entry count update
    typedef enum logic [1:0] {
        USED_HOLD,
        USED_INC,
        USED_DEC
    } used_op_t;

    // step addresses of the microprogram
    typedef logic [4:0] step_t;

    localparam step_t S_EMIT     = 5'd0;
    localparam step_t S_IDLE     = 5'd1;
    localparam step_t S_DISP     = 5'd2;
    localparam step_t S_FULLCHK  = 5'd3;
    localparam step_t S_INS_INIT = 5'd4;
    localparam step_t S_INS_TEST = 5'd5;
    localparam step_t S_INS_RD   = 5'd6;
    localparam step_t S_INS_CMP  = 5'd7;
    localparam step_t S_INS_MOV  = 5'd8;
    localparam step_t S_INS_PUT  = 5'd9;
    localparam step_t S_SD_EMPTY = 5'd10;
    localparam step_t S_SD_INIT  = 5'd11;
    localparam step_t S_SD_RD    = 5'd12;
    localparam step_t S_SD_CMP   = 5'd13;
    localparam step_t S_SD_NEXT  = 5'd14;
    localparam step_t S_R_NFND   = 5'd15;
    localparam step_t S_SD_HIT   = 5'd16;
    localparam step_t S_DEL_TEST = 5'd17;
    localparam step_t S_DEL_RD   = 5'd18;
    localparam step_t S_DEL_MOV  = 5'd19;
    localparam step_t S_DEL_DONE = 5'd20;
    localparam step_t S_R_OK     = 5'd21;
    localparam step_t S_R_FULL   = 5'd22;
    localparam step_t S_R_EMPTY  = 5'd23;

    // one control word
    typedef struct packed {
        cond_t    cond;
        step_t    target;
        logic     take_in;
        idx_op_t  idx_op;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     pos_ld;
        used_op_t used_op;
        logic     st_ld;
        status_t  st_code;
        logic     out_ld;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic not_ins;
        logic not_del;
        logic full;
        logic empty;
        logic idx_zero;
        logic not_gt;
        logic eq;
        logic last;
        logic out_busy;
    } flags_t;

    localparam uword_t UW_NOP = '{
        cond:    C_NONE,
        target:  S_IDLE,
        take_in: 1'b0,
        idx_op:  IDX_HOLD,
        rd_sel:  RD_NONE,
        wr_sel:  WR_NONE,
        pos_ld:  1'b0,
        used_op: USED_HOLD,
        st_ld:   1'b0,
        st_code: ST_OK,
        out_ld:  1'b0
    };

    // microprogram rom
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        w = UW_NOP;
        case (step)
            // hand the result over once the output register is free
            S_EMIT:
            begin
                w.cond   = C_OUT_BUSY;
                w.target = S_EMIT;
                w.out_ld = 1'b1;
            end
            // take the next word
            S_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = C_NO_INPUT;
                w.target  = S_IDLE;
            end
            S_DISP:
            begin
                w.cond   = C_NOT_INS;
                w.target = S_SD_EMPTY;
            end
            S_FULLCHK:
            begin
                w.cond   = C_FULL;
                w.target = S_R_FULL;
            end
            // insert: walk down from the top, moving greater entries up
            S_INS_INIT:
            begin
                w.idx_op = IDX_USED;
            end
            S_INS_TEST:
            begin
                w.cond   = C_IDX_ZERO;
                w.target = S_INS_PUT;
            end
            S_INS_RD:
            begin
                w.rd_sel = RD_IDX_M1;
            end
            S_INS_CMP:
            begin
                w.cond   = C_NOT_GT;
                w.target = S_INS_PUT;
            end
            S_INS_MOV:
            begin
                w.wr_sel = WR_DATA;
                w.idx_op = IDX_DEC;
                w.cond   = C_ALWAYS;
                w.target = S_INS_TEST;
            end
            S_INS_PUT:
            begin
                w.wr_sel  = WR_VAL;
                w.pos_ld  = 1'b1;
                w.used_op = USED_INC;
                w.st_ld   = 1'b1;
                w.st_code = ST_OK;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            // search and delete: scan up for the first match
            S_SD_EMPTY:
            begin
                w.cond   = C_EMPTY;
                w.target = S_R_EMPTY;
            end
            S_SD_INIT:
            begin
                w.idx_op = IDX_ZERO;
            end
            S_SD_RD:
            begin
                w.rd_sel = RD_IDX;
            end
            S_SD_CMP:
            begin
                w.pos_ld = 1'b1;
                w.cond   = C_EQ;
                w.target = S_SD_HIT;
            end
            S_SD_NEXT:
            begin
                w.idx_op = IDX_INC;
                w.cond   = C_NOT_LAST;
                w.target = S_SD_RD;
            end
            S_R_NFND:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_NOTFOUND;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            S_SD_HIT:
            begin
                w.cond   = C_NOT_DEL;
                w.target = S_R_OK;
            end
            // delete: move later entries down by one
            S_DEL_TEST:
            begin
                w.cond   = C_LAST;
                w.target = S_DEL_DONE;
            end
            S_DEL_RD:
            begin
                w.rd_sel = RD_IDX_P1;
            end
            S_DEL_MOV:
            begin
                w.wr_sel = WR_DATA;
                w.idx_op = IDX_INC;
                w.cond   = C_ALWAYS;
                w.target = S_DEL_TEST;
            end
            S_DEL_DONE:
            begin
                w.used_op = USED_DEC;
                w.st_ld   = 1'b1;
                w.st_code = ST_OK;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            S_R_OK:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_OK;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            S_R_FULL:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_FULL;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            S_R_EMPTY:
            begin
                w.st_ld   = 1'b1;
                w.st_code = ST_EMPTY;
                w.cond    = C_ALWAYS;
                w.target  = S_EMIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sle_useq.sv
// ----------------------------------------------------------------------------
// sle_useq
// Microcode sequencer: step counter, control word rom and conditional jumps.
// ----------------------------------------------------------------------------
module sle_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  sle_pkg::flags_t flags,
    output sle_pkg::uword_t uw
);

    import sle_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    // control word of the current step
    assign uw = ucode_rom(step_reg);

    // jump condition select
    always_comb
    begin
        case (uw.cond)
            C_NONE:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !flags.in_valid;
            C_NOT_INS:  jump = flags.not_ins;
            C_FULL:     jump = flags.full;
            C_EMPTY:    jump = flags.empty;
            C_IDX_ZERO: jump = flags.idx_zero;
            C_NOT_GT:   jump = flags.not_gt;
            C_EQ:       jump = flags.eq;
            C_NOT_LAST: jump = !flags.last;
            C_LAST:     jump = flags.last;
            C_NOT_DEL:  jump = flags.not_del;
            C_OUT_BUSY: jump = flags.out_busy;
            default:    jump = 1'b0;
        endcase
    end

    // next step
    assign step_next = jump ? uw.target : step_reg + step_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: design/sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Bounded ascending list of signed 32-bit values with insert, delete and
// search, run by a microcoded sequencer over a one-read one-write entry memory.
// ----------------------------------------------------------------------------
// One operation is taken at a time and gives one result word. The entries sit
// in one memory with one read and one write per cycle and registered read, so
// the program walks them one at a time. A search scans the entries from the
// front, an insert moves greater entries up one by one from the top, and a
// delete runs the search and then moves the later entries down one by one.
// The idle step then takes the next word, and a stalled result holds the
// program in the emit step until the output register is free. For DEPTH of 4
// or more the worst case is an insert at the front of a list one short of
// full. A new word is taken while the previous result still waits in the
// output register. Equal values keep arrival order; delete and search act
// on the first match. The list starts empty after reset, with no clearing
// pass.
module sorted_list_engine_core #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sle_pkg::MODE_W-1:0]          mode,
    input  logic signed [sle_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sle_pkg::STATUS_W-1:0]        status,
    output logic [sle_pkg::POS_W-1:0]           position,
    output logic [sle_pkg::COUNT_W-1:0]         count
);

    import sle_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    uword_t uw;
    flags_t flags;

    logic [MODE_W-1:0]   mode_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [CW-1:0]       idx_p1;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       used_next;
    status_t             st_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [POS_W-1:0]    res_pos_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic                in_take;
    logic                out_load;
    logic [CW+POS_W-1:0]   pos_ext;
    logic [CW+COUNT_W-1:0] used_ext;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    // sequencer
    sle_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uw    (uw)
    );

    // entry store
    sle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input handshake
    assign in_stall = !uw.take_in;
    assign in_take  = uw.take_in && in_valid;

    // datapath status for the sequencer
    assign idx_p1 = idx_reg + CW'(1);

    always_comb
    begin
        flags.in_valid = in_valid;
        flags.not_ins  = (mode_reg != MODE_INSERT);
        flags.not_del  = (mode_reg != MODE_DELETE);
        flags.full     = (used_reg == CW'(DEPTH));
        flags.empty    = (used_reg == '0);
        flags.idx_zero = (idx_reg == '0);
        flags.not_gt   = ($signed(ram_rdata) <= $signed(val_reg));
        flags.eq       = (ram_rdata == val_reg);
        flags.last     = (idx_p1 == used_reg);
        flags.out_busy = out_valid_reg && out_stall;
    end

    // memory address and data select
    always_comb
    begin
        ram_re = (uw.rd_sel != RD_NONE);
        case (uw.rd_sel)
            RD_IDX_M1: ram_raddr = AW'(idx_reg - CW'(1));
            RD_IDX:    ram_raddr = AW'(idx_reg);
            RD_IDX_P1: ram_raddr = AW'(idx_p1);
            default:   ram_raddr = AW'(idx_reg);
        endcase
    end

    assign ram_we    = (uw.wr_sel != WR_NONE);
    assign ram_waddr = AW'(idx_reg);
    assign ram_wdata = (uw.wr_sel == WR_VAL) ? val_reg : ram_rdata;

    // index register update
    always_comb
    begin
        case (uw.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_USED: idx_next = used_reg;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_p1;
            IDX_DEC:  idx_next = idx_reg - CW'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    // entry count update
    always_comb
    begin
        case (uw.used_op)
            USED_HOLD: used_next = used_reg;
            USED_INC:  used_next = used_reg + CW'(1);
            USED_DEC:  used_next = used_reg - CW'(1);
            default:   used_next = used_reg;
        endcase
    end

    // output register
    assign out_load = uw.out_ld && !flags.out_busy;
    assign pos_ext  = {{POS_W{1'b0}}, pos_reg};
    assign used_ext = {{COUNT_W{1'b0}}, used_reg};

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            val_reg  <= value;
        end
        idx_reg <= idx_next;
        if (uw.pos_ld)
        begin
            pos_reg <= idx_reg;
        end
        if (uw.st_ld)
        begin
            st_reg <= uw.st_code;
        end
        if (out_load)
        begin
            res_status_reg <= st_reg;
            res_pos_reg    <= (st_reg == ST_OK) ? pos_ext[POS_W-1:0] : '0;
            res_count_reg  <= used_ext[COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = res_status_reg;
    assign position  = res_pos_reg;
    assign count     = res_count_reg;

    // the list never holds more than its depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // writes stay inside the stored part of the list or one past it
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> idx_reg <= used_reg)
        else $error("entry write beyond list end");

    // the count only moves on a step that updates it
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> $past(uw.used_op != USED_HOLD))
        else $error("entry count changed outside an update step");

    // a new result word only comes from the emit step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(uw.out_ld))
        else $error("result word without emit step");

    // a failed operation reports position zero
    a_pos_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_status_reg != ST_OK)) |-> (res_pos_reg == '0))
        else $error("nonzero position on failed operation");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_list_engine_core. A queue of operation words
// (directed corner cases, then random traffic aimed at hits, full and empty
// lists) feeds a bursty driver. The monitor keeps its own copy of the ordered
// list, predicts every result and compares each returned word field by field.
// ----------------------------------------------------------------------------
module tb;

    import sle_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    // search codes, the spare code also decodes as search
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // receiver hold-off that backs the engine up
    localparam int HOLD_PERIOD = 10000;
    localparam int HOLD_START  = 2000;
    localparam int HOLD_CYCLES = 500;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_style_t;

    typedef struct {
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] val;
        bit                       drain_first;
    } op_item_t;

    typedef struct packed {
        status_t              st;
        logic [POS_W-1:0]     pos;
        logic [COUNT_W-1:0]   cnt;
    } list_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [MODE_W-1:0]           mode = MODE_INSERT;
    logic signed [DATA_W-1:0]    value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic [POS_W-1:0]            position;
    logic [COUNT_W-1:0]          count;

    op_item_t                    op_queue[$];
    list_result_t                expected_results[$];
    logic signed [DATA_W-1:0]    gen_pool[$];

    // predicted list contents
    logic signed [DATA_W-1:0]    shadow_vals[LIST_DEPTH];
    int                          shadow_len = 0;

    int                          accepted_n = 0;
    int                          checked_n = 0;
    int                          errors = 0;
    int                          burst_left = 0;
    int                          gap_left = 0;
    int                          stretch_left = 0;
    int                          hold_left = 0;
    int                          cyc = 0;
    stall_style_t                stall_style = STALL_NONE;
    op_item_t                    next_op;
    list_result_t                got_res;
    list_result_t                want_res;
    list_result_t                new_res;
    bit                          all_back;

    sorted_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position),
        .count     (count)
    );

    always #2 clk = ~clk;

    // apply one operation to the predicted list and return its result word
    task automatic list_apply(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] v,
                              output list_result_t r);
        int  slot;
        int  i;
        bit  hit;
        r.st = ST_OK;
        slot = 0;
        hit  = 1'b0;
        if (op == MODE_INSERT)
        begin
            if (shadow_len >= LIST_DEPTH)
                r.st = ST_FULL;
            else
            begin
                // first entry strictly greater, equal values stay in order
                slot = shadow_len;
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_vals[i] > v)
                        slot = i;
                for (i = shadow_len; i > slot; i--)
                    shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[slot] = v;
                shadow_len++;
            end
        end
        else if (shadow_len == 0)
            r.st = ST_EMPTY;
        else
        begin
            for (i = 0; i < shadow_len; i++)
                if (!hit && shadow_vals[i] == v)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            if (!hit)
            begin
                r.st = ST_NOTFOUND;
                slot = 0;
            end
            else if (op == MODE_DELETE)
            begin
                for (i = slot; i + 1 < shadow_len; i++)
                    shadow_vals[i] = shadow_vals[i+1];
                shadow_len--;
            end
        end
        r.pos = slot[POS_W-1:0];
        r.cnt = shadow_len[COUNT_W-1:0];
    endtask

    // queue one word and track what the list will hold for later picks
    task automatic queue_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] v,
                            input bit drain);
        int idx[$];
        op_queue.push_back('{op: op, val: v, drain_first: drain});
        if (op == MODE_INSERT)
        begin
            if (gen_pool.size() < LIST_DEPTH)
                gen_pool.push_back(v);
        end
        else if (op == MODE_DELETE)
        begin
            idx = gen_pool.find_first_index(x) with (x == v);
            if (idx.size() != 0)
                gen_pool.delete(idx[0]);
        end
    endtask

    // about half stored values, then fixed extremes and values near zero, some wide random
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (gen_pool.size() != 0 && sel < 50)
            return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
        if (sel < 80)
        begin
            case ($urandom_range(0, 6))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -32'sd2;
                3: return -32'sd1;
                4: return 32'sd0;
                5: return 32'sd1;
                default: return 32'sd2;
            endcase
        end
        return $urandom;
    endfunction

    // driver: bursts of words with random gaps, optional drain before a word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= MODE_INSERT;
            value      <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            all_back = (accepted_n + int'(in_valid && !in_stall))
                       == (checked_n + int'(out_valid && !out_stall));
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (op_queue.size() == 0)
                in_valid <= 1'b0;
            else if (op_queue[0].drain_first && !all_back)
                in_valid <= 1'b0;
            else
            begin
                next_op = op_queue.pop_front();
                in_valid <= 1'b1;
                mode     <= next_op.op;
                value    <= next_op.val;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern with a periodic long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_style  <= STALL_NONE;
            stretch_left <= 0;
            hold_left    <= 0;
            cyc          <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (cyc % HOLD_PERIOD == HOLD_START)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_style  <= stall_style_t'($urandom_range(0, 2));
                    stretch_left <= $urandom_range(20, 150);
                end
                else
                    stretch_left <= stretch_left - 1;
                case (stall_style)
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
                    default:     out_stall <= 1'b0;
                endcase
            end
        end
    end

    // monitor: check returned words, then predict for accepted words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_res.st  = status_t'(status);
                got_res.pos = position;
                got_res.cnt = count;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: status %0d position %0d count %0d",
                             $time, status, position, count);
                    errors++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (got_res.st != want_res.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_res.st, got_res.st);
                        errors++;
                    end
                    if (got_res.pos != want_res.pos)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want_res.pos, got_res.pos);
                        errors++;
                    end
                    if (got_res.cnt != want_res.cnt)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want_res.cnt, got_res.cnt);
                        errors++;
                    end
                end
                checked_n <= checked_n + 1;
            end
            if (in_valid && !in_stall)
            begin
                list_apply(mode, value, new_res);
                expected_results.push_back(new_res);
                accepted_n <= accepted_n + 1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int n;
        int sel;
        logic [MODE_W-1:0] op;

        // empty list corner cases
        queue_op(MODE_SEARCH, 32'sd0, 1'b0);
        queue_op(MODE_DELETE, 32'sd5, 1'b0);
        queue_op(MODE_SPARE, 32'sd7, 1'b0);
        // fill with extremes and duplicates
        queue_op(MODE_INSERT, VAL_MAX, 1'b0);
        queue_op(MODE_INSERT, VAL_MIN, 1'b0);
        queue_op(MODE_INSERT, 32'sd0, 1'b0);
        queue_op(MODE_INSERT, 32'sd0, 1'b0);
        queue_op(MODE_INSERT, -32'sd1, 1'b0);
        queue_op(MODE_INSERT, 32'sd1, 1'b0);
        queue_op(MODE_SEARCH, 32'sd0, 1'b0);
        queue_op(MODE_SPARE, VAL_MIN, 1'b0);
        queue_op(MODE_DELETE, 32'sd42, 1'b0);
        queue_op(MODE_INSERT, 32'sh7FFF_FFFE, 1'b0);
        queue_op(MODE_INSERT, VAL_MIN, 1'b0);
        // full list
        queue_op(MODE_INSERT, 32'sd5, 1'b0);
        queue_op(MODE_SEARCH, VAL_MAX, 1'b0);
        queue_op(MODE_DELETE, 32'sd0, 1'b0);
        queue_op(MODE_DELETE, VAL_MIN, 1'b0);
        queue_op(MODE_DELETE, VAL_MAX, 1'b0);
        queue_op(MODE_SEARCH, 32'sd12345, 1'b0);
        queue_op(MODE_INSERT, 32'sh5555_5555, 1'b0);
        queue_op(MODE_INSERT, 32'shAAAA_AAAA, 1'b0);

        // random traffic, a drain pause now and then
        for (n = 0; n < 2000; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                op = MODE_INSERT;
            else if (sel < 72)
                op = MODE_DELETE;
            else if (sel < 94)
                op = MODE_SEARCH;
            else
                op = MODE_SPARE;
            queue_op(op, pick_value(), (n % 250 == 0));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid || accepted_n != checked_n)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run time limit
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
